// ----- design/branch_target_buffer_lru_unit_assert.svh -----
// assertion macros for the branch target buffer checker
// expects clk_i and rst_ni in the scope of use
`ifndef BRANCH_TARGET_BUFFER_LRU_UNIT_ASSERT_SVH
`define BRANCH_TARGET_BUFFER_LRU_UNIT_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define BTB_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define BTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/btb_lru_pkg.sv -----
// shared types and constants for the branch target buffer
// no dependencies
package btb_lru_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam logic [31:0] NEXT_STEP = 32'd4;

  typedef enum logic {
    KIND_PREDICT = 1'b0,
    KIND_UPDATE  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] branch_address;
    logic [31:0] target_address;
    logic        taken;
  } btb_in_t;

  typedef struct packed {
    logic [31:0] next_address;
    logic        hit;
    logic        evicted;
    logic [4:0]  entry_count;
  } btb_out_t;

endpackage

// ----- design/btb_lru_table.sv -----
// entry storage, parallel lookup and least-recently-updated replacement
// depends on btb_lru_pkg
module btb_lru_table #(
  parameter int unsigned ENTRIES = btb_lru_pkg::ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  btb_lru_pkg::btb_in_t  item_i,
  output btb_lru_pkg::btb_out_t result_o
);
  import btb_lru_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [AW-1:0] AGE_MAX = AW'(ENTRIES - 1);

  logic [ENTRIES-1:0] valid_q;
  logic [AW-1:0]      age_q [ENTRIES];
  logic [CW-1:0]      count_q, count_d;
  logic [31:0]        branch_q [ENTRIES];
  logic [31:0]        target_q [ENTRIES];
  logic [ENTRIES-1:0] taken_q;

  logic [ENTRIES-1:0] match, free_slots, first_free, victim, wsel, bump;
  logic [31:0]        tgt_sel;
  logic               tk_sel;
  logic [AW-1:0]      age_hit;
  logic               hit, full, is_upd, grow;

  always_comb begin
    match   = '0;
    victim  = '0;
    tgt_sel = '0;
    tk_sel  = 1'b0;
    age_hit = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_q[i] && (branch_q[i] == item_i.branch_address);
      victim[i] = valid_q[i] && (age_q[i] == AGE_MAX);
      // keys are unique, so at most one entry matches
      if (match[i]) begin
        tgt_sel = tgt_sel | target_q[i];
        tk_sel  = tk_sel | taken_q[i];
        age_hit = age_hit | age_q[i];
      end
    end
  end

  assign hit        = |match;
  assign full       = &valid_q;
  assign is_upd     = (item_i.kind == KIND_UPDATE);
  assign free_slots = ~valid_q;
  // lowest free slot
  assign first_free = free_slots & (~free_slots + ENTRIES'(1));
  assign grow       = is_upd && !hit && !full;
  assign count_d    = grow ? count_q + CW'(1) : count_q;

  always_comb begin
    if (!is_upd) begin
      wsel = '0;
    end else if (hit) begin
      wsel = match;
    end else if (full) begin
      wsel = victim;
    end else begin
      wsel = first_free;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      bump[i] = is_upd && valid_q[i] && !wsel[i] && (!hit || (age_q[i] < age_hit));
    end
  end

  always_comb begin
    result_o.hit          = hit;
    result_o.evicted      = is_upd && !hit && full;
    result_o.entry_count  = 5'(count_d);
    if (is_upd) begin
      result_o.next_address = '0;
    end else if (hit && tk_sel) begin
      result_o.next_address = tgt_sel;
    end else begin
      result_o.next_address = item_i.branch_address + NEXT_STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else if (fire_i) begin
      count_q <= count_d;
      for (int i = 0; i < ENTRIES; i++) begin
        if (wsel[i]) begin
          valid_q[i] <= 1'b1;
          age_q[i]   <= '0;
        end else if (bump[i]) begin
          age_q[i] <= age_q[i] + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (wsel[i]) begin
          branch_q[i] <= item_i.branch_address;
          target_q[i] <= item_i.target_address;
          taken_q[i]  <= item_i.taken;
        end
      end
    end
  end

endmodule

// ----- design/branch_target_buffer_lru_unit.sv -----
// channel   | dir | handshake             | payload
// in        | in  | in_valid_i/in_ready_o  | in_data_i  (btb_in_t)
// out       | out | out_valid_o/out_ready_i| out_data_o (btb_out_t)
// one transaction per cycle while the result is not stalled; input register, then result register
// the rate is set by the parallel tag compare in the entry table, which is combinational
// an input register feeds the table; table state and result register update together
// a stalled result holds the input register, which still accepts while it is empty
// reset clears valid bits, ages and the entry count; no clearing pass
// top level of the branch target buffer; depends on btb_lru_pkg and btb_lru_table
module branch_target_buffer_lru_unit #(
  parameter int unsigned ENTRIES = btb_lru_pkg::ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  btb_lru_pkg::btb_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output btb_lru_pkg::btb_out_t out_data_o
);
  import btb_lru_pkg::*;

  logic     s1_valid_q, s1_valid_d;
  btb_in_t  s1_data_q;
  logic     out_valid_q, out_valid_d;
  btb_out_t out_data_q;
  btb_out_t result;
  logic     advance;

  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign s1_valid_d  = in_ready_o ? in_valid_i : s1_valid_q;
  assign out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  btb_lru_table #(
    .ENTRIES(ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .item_i  (s1_data_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- design/btb_lru_checker.sv -----
// port-level checks for the branch target buffer, bound to the top level
// depends on btb_lru_pkg and branch_target_buffer_lru_unit_assert.svh
`include "branch_target_buffer_lru_unit_assert.svh"

module btb_lru_checker #(
  parameter int unsigned ENTRIES = btb_lru_pkg::ENTRIES_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input btb_lru_pkg::btb_out_t out_data_o
);
  import btb_lru_pkg::*;

  localparam logic [4:0] FULL_CNT = 5'(ENTRIES);

  logic [4:0] cnt_q;
  logic [1:0] pending_q, pending_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_acc && !out_acc) begin
      pending_d = pending_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
      if (out_acc) begin
        cnt_q <= out_data_o.entry_count;
      end
    end
  end

  `BTB_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result changed while stalled")
  `BTB_ASSERT(a_no_orphan, !out_valid_o || (pending_q != 2'd0), "result without accepted transaction")
  `BTB_ASSERT(a_evict_full, !(out_valid_o && out_data_o.evicted) || (!out_data_o.hit && out_data_o.next_address == 32'd0 && out_data_o.entry_count == FULL_CNT), "eviction from a table that is not full")
  `BTB_ASSERT(a_count_step, !out_valid_o || out_data_o.entry_count == cnt_q || out_data_o.entry_count == cnt_q + 5'd1, "entry count jumped")

endmodule

bind branch_target_buffer_lru_unit btb_lru_checker #(.ENTRIES(ENTRIES)) u_checker (.*);
